// ----- src/tkbsgr_pkg.sv -----
// Package: widths, defaults and register indexes of the bad sector gap ranker.
`default_nettype none
package tkbsgr_pkg;
   localparam int MAX_RANKS_DEF    = 16;
   localparam int ADDRESS_BITS_DEF = 48;
   localparam int RESULT_LIMIT     = 16;
   localparam int FIELD_W          = 48;
   localparam int TIME_W           = 32;
   localparam int RANK_W           = 4;
   localparam int RANKS_W          = 5;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 48;
   localparam logic [RANKS_W-1:0] RANKS_RESET = 5'd10;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_LBA     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANKS_IN_USE = 1'd1;
   localparam logic OP_SECTOR = 1'b0;
   localparam logic OP_REPORT = 1'b1;
endpackage
`default_nettype wire

// ----- src/top_k_bad_sector_gap_ranker.sv -----
// Top level: ranks the longest spans of good sectors between bad sectors.
//
// Usage: a request is taken when start is high and busy is low. A sector record
// (op = sector) with a non-negative access time changes nothing and leaves busy
// low. A bad sector record closes the open span and inserts it into a sorted
// table kept in a small memory: the sequencer walks from the bottom of the table
// upward, reading each entry and then comparing it and moving it down. An end
// record (op = report) inserts the final span, then emits one result per filled
// rank on consecutive cycles, each marked by rsp_valid for one cycle, rsp_last on
// the final one, after which the scan state is cleared. The receiver cannot
// stall; results are never held back. Registers are written through
// csr_we/csr_index/csr_wdata; the user must write them only while busy is low,
// which the block itself does not enforce. Reset (synchronous) clears the scan
// state and restores the register defaults; the table memory needs no clearing
// since only filled entries are read.
`default_nettype none
module top_k_bad_sector_gap_ranker #(
   parameter int MAX_RANKS    = tkbsgr_pkg::MAX_RANKS_DEF,
   parameter int ADDRESS_BITS = tkbsgr_pkg::ADDRESS_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_op,
   input  wire logic [tkbsgr_pkg::FIELD_W-1:0]      req_sector_address,
   input  wire logic signed [tkbsgr_pkg::TIME_W-1:0] req_access_time,
   output logic                                     rsp_valid,
   output logic [tkbsgr_pkg::RANK_W-1:0]            rsp_rank,
   output logic [tkbsgr_pkg::FIELD_W-1:0]           rsp_span_start,
   output logic [tkbsgr_pkg::FIELD_W-1:0]           rsp_span_end,
   output logic [tkbsgr_pkg::FIELD_W-1:0]           rsp_span_length,
   output logic [tkbsgr_pkg::FIELD_W-1:0]           rsp_bad_count,
   output logic                                     rsp_last,
   input  wire logic                                csr_we,
   input  wire logic [tkbsgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tkbsgr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int FW    = tkbsgr_pkg::FIELD_W;
   localparam int AW    = (ADDRESS_BITS < FW) ? ADDRESS_BITS : FW;
   localparam int DEPTH = (MAX_RANKS < tkbsgr_pkg::RESULT_LIMIT) ? MAX_RANKS
                          : tkbsgr_pkg::RESULT_LIMIT;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int RW    = tkbsgr_pkg::RANKS_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INSERT, ST_FULL_RD, ST_FULL_CMP, ST_WALK_RD, ST_WALK_CMP,
      ST_RPT, ST_CLEAR
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] disk_lba_ff, disk_lba_in;
   logic [RW-1:0] ranks_ff, ranks_in;
   logic [AW-1:0] open_ff, open_in;
   logic [FW-1:0] bad_ff, bad_in;
   logic [CW-1:0] filled_ff, filled_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] rpt_ff, rpt_in;
   logic          is_end_ff, is_end_in;
   logic [AW-1:0] new_start_ff, new_start_in;
   logic [AW-1:0] new_end_ff, new_end_in;
   logic [AW-1:0] new_len_ff, new_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_rank_ff, rsp_rank_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [AW-1:0] mem_start [DEPTH];
   logic [AW-1:0] mem_end   [DEPTH];
   logic [AW-1:0] mem_len   [DEPTH];
   logic [AW-1:0] rd_start_ff, rd_end_ff, rd_len_ff;
   logic [IW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [AW-1:0] wr_start, wr_end, wr_len;

   logic [CW-1:0] k_lim, n_cnt;
   logic [AW-1:0] span_e;
   logic [AW:0]   span_diff;
   logic [AW-1:0] span_len;

   always_comb begin
      if (ranks_ff == '0) begin
         k_lim = CW'(1);
      end else if (ranks_ff > RW'(DEPTH)) begin
         k_lim = CW'(DEPTH);
      end else begin
         k_lim = CW'(ranks_ff);
      end
      n_cnt = (filled_ff < k_lim) ? filled_ff : k_lim;
   end

   assign span_e    = (req_op == tkbsgr_pkg::OP_REPORT) ? disk_lba_ff
                      : req_sector_address[AW-1:0];
   assign span_diff = {1'b0, span_e} - {1'b0, open_ff};
   assign span_len  = span_diff[AW] ? '0 : span_diff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      disk_lba_in  = disk_lba_ff;
      ranks_in     = ranks_ff;
      open_in      = open_ff;
      bad_in       = bad_ff;
      filled_in    = filled_ff;
      idx_in       = idx_ff;
      rpt_in       = rpt_ff;
      is_end_in    = is_end_ff;
      new_start_in = new_start_ff;
      new_end_in   = new_end_ff;
      new_len_in   = new_len_ff;
      rsp_valid_in = 1'b0;
      rsp_rank_in  = rsp_rank_ff;
      rsp_last_in  = rsp_last_ff;
      rd_addr      = idx_ff - IW'(1);
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_start     = new_start_ff;
      wr_end       = new_end_ff;
      wr_len       = new_len_ff;

      if (csr_we) begin
         case (csr_index)
            tkbsgr_pkg::CSR_DISK_LBA:     disk_lba_in = csr_wdata[AW-1:0];
            tkbsgr_pkg::CSR_RANKS_IN_USE: ranks_in = csr_wdata[RW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               new_start_in = open_ff;
               new_end_in   = span_e;
               new_len_in   = span_len;
               if (req_op == tkbsgr_pkg::OP_REPORT) begin
                  is_end_in = 1'b1;
                  state_in  = ST_INSERT;
               end else if (req_access_time[tkbsgr_pkg::TIME_W-1]) begin
                  is_end_in = 1'b0;
                  bad_in    = bad_ff + FW'(1);
                  open_in   = span_e;
                  state_in  = ST_INSERT;
               end
            end
         end
         ST_INSERT: begin
            filled_in = n_cnt;
            if (n_cnt == k_lim) begin
               idx_in   = IW'(k_lim - CW'(1));
               state_in = ST_FULL_RD;
            end else begin
               idx_in   = IW'(n_cnt);
               state_in = ST_WALK_RD;
            end
         end
         ST_FULL_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_FULL_CMP;
         end
         ST_FULL_CMP: begin
            if (new_len_ff <= rd_len_ff) begin
               state_in = is_end_ff ? ST_RPT : ST_IDLE;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            if (idx_ff == '0) begin
               wr_en     = 1'b1;
               filled_in = (filled_ff < k_lim) ? filled_ff + CW'(1) : filled_ff;
               state_in  = is_end_ff ? ST_RPT : ST_IDLE;
            end else begin
               state_in = ST_WALK_CMP;
            end
         end
         ST_WALK_CMP: begin
            wr_en = 1'b1;
            if (rd_len_ff >= new_len_ff) begin
               filled_in = (filled_ff < k_lim) ? filled_ff + CW'(1) : filled_ff;
               state_in  = is_end_ff ? ST_RPT : ST_IDLE;
            end else begin
               // entry above moves down one rank
               wr_start = rd_start_ff;
               wr_end   = rd_end_ff;
               wr_len   = rd_len_ff;
               idx_in   = idx_ff - IW'(1);
               state_in = ST_WALK_RD;
            end
         end
         ST_RPT: begin
            rd_addr      = rpt_ff;
            rsp_valid_in = 1'b1;
            rsp_rank_in  = rpt_ff;
            rsp_last_in  = (CW'(rpt_ff) + CW'(1)) == filled_ff;
            rpt_in       = rpt_ff + IW'(1);
            if (rsp_last_in) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            open_in   = '0;
            bad_in    = '0;
            filled_in = '0;
            rpt_in    = '0;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         disk_lba_ff  <= '0;
         ranks_ff     <= tkbsgr_pkg::RANKS_RESET;
         open_ff      <= '0;
         bad_ff       <= '0;
         filled_ff    <= '0;
         idx_ff       <= '0;
         rpt_ff       <= '0;
         is_end_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_rank_ff  <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         disk_lba_ff  <= disk_lba_in;
         ranks_ff     <= ranks_in;
         open_ff      <= open_in;
         bad_ff       <= bad_in;
         filled_ff    <= filled_in;
         idx_ff       <= idx_in;
         rpt_ff       <= rpt_in;
         is_end_ff    <= is_end_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_rank_ff  <= rsp_rank_in;
         rsp_last_ff  <= rsp_last_in;
      end
      new_start_ff <= new_start_in;
      new_end_ff   <= new_end_in;
      new_len_ff   <= new_len_in;
   end

   // ranking table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start;
         mem_end[wr_addr]   <= wr_end;
         mem_len[wr_addr]   <= wr_len;
      end
      rd_start_ff <= mem_start[rd_addr];
      rd_end_ff   <= mem_end[rd_addr];
      rd_len_ff   <= mem_len[rd_addr];
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rank        = tkbsgr_pkg::RANK_W'(rsp_rank_ff);
   assign rsp_span_start  = FW'(rd_start_ff);
   assign rsp_span_end    = FW'(rd_end_ff);
   assign rsp_span_length = FW'(rd_len_ff);
   assign rsp_bad_count   = bad_ff;
   assign rsp_last        = rsp_last_ff;
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for the bad sector gap ranker: directed plan, then random scans checked by a predictor.
`timescale 1ns / 100ps
module tb;
   import tkbsgr_pkg::*;

   typedef logic [FIELD_W-1:0] addr_t;
   typedef logic [TIME_W-1:0]  stamp_t;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      addr_t             from_lba;
      addr_t             to_lba;
      addr_t             length;
      addr_t             bad_count;
      logic              is_last;
   } span_t;

   typedef enum {ROW_REQ, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e             kind;
      logic                  op;
      addr_t                 addr;
      stamp_t                tm;
      logic [CSR_IDX_W-1:0]  idx;
      bit                    typed;
      span_t                 want;
   } row_t;

   localparam addr_t LBA_MAX       = '1;
   localparam int    SETTLE_CYCLES = 2 * RESULT_LIMIT + 8;
   localparam int    STALL_LIMIT   = 1000;
   localparam int    RANDOM_ITEMS  = 150;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  start              = 1'b0;
   logic                  busy;
   logic                  req_op             = OP_SECTOR;
   addr_t                 req_sector_address = '0;
   stamp_t                req_access_time    = '0;
   logic                  rsp_valid;
   logic [RANK_W-1:0]     rsp_rank;
   addr_t                 rsp_span_start;
   addr_t                 rsp_span_end;
   addr_t                 rsp_span_length;
   addr_t                 rsp_bad_count;
   logic                  rsp_last;
   logic                  csr_we             = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index          = CSR_DISK_LBA;
   logic [CSR_DATA_W-1:0] csr_wdata          = '0;

   top_k_bad_sector_gap_ranker dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_sector_address (req_sector_address),
      .req_access_time    (req_access_time),
      .rsp_valid          (rsp_valid),
      .rsp_rank           (rsp_rank),
      .rsp_span_start     (rsp_span_start),
      .rsp_span_end       (rsp_span_end),
      .rsp_span_length    (rsp_span_length),
      .rsp_bad_count      (rsp_bad_count),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor state
   addr_t       disk_lba_cfg;
   logic [4:0]  ranks_cfg;
   addr_t       open_start;
   addr_t       bad_total;
   addr_t       rank_from [MAX_RANKS_DEF];
   addr_t       rank_to   [MAX_RANKS_DEF];
   int unsigned ranks_filled;

   span_t fresh_spans [$];
   span_t span_due [$];
   row_t  directed_plan [$];

   int  mismatch_count = 0;
   int  spans_checked  = 0;
   int  good_sent      = 0;
   int  bad_sent       = 0;
   int  reports_sent   = 0;
   int  csr_writes     = 0;
   int  quiet_cycles   = 0;
   bit  no_gaps        = 1'b0;

   function automatic addr_t gap_len(addr_t s, addr_t e);
      return (e >= s) ? e - s : '0;
   endfunction

   function automatic addr_t rand48();
      return addr_t'({$urandom, $urandom});
   endfunction

   function automatic void clear_scan();
      open_start   = '0;
      bad_total    = '0;
      ranks_filled = 0;
      foreach (rank_from[i]) begin
         rank_from[i] = '0;
         rank_to[i]   = '0;
      end
   endfunction

   function automatic int unsigned rank_cap();
      int unsigned k;
      k = ranks_cfg;
      if (k < 1) k = 1;
      if (k > MAX_RANKS_DEF) k = MAX_RANKS_DEF;
      if (k > RESULT_LIMIT) k = RESULT_LIMIT;
      return k;
   endfunction

   function automatic void file_span(addr_t s, addr_t e);
      int unsigned k;
      int unsigned n;
      int unsigned pos;
      int unsigned i;
      addr_t       len;
      k   = rank_cap();
      n   = (ranks_filled < k) ? ranks_filled : k;
      len = gap_len(s, e);
      pos = 0;
      ranks_filled = n;
      if (n == k && len <= gap_len(rank_from[k-1], rank_to[k-1])) return;
      while (pos < n && gap_len(rank_from[pos], rank_to[pos]) >= len) pos++;
      for (i = (n < k) ? n : k - 1; i > pos; i--) begin
         rank_from[i] = rank_from[i-1];
         rank_to[i]   = rank_to[i-1];
      end
      rank_from[pos] = s;
      rank_to[pos]   = e;
      ranks_filled   = (n < k) ? n + 1 : k;
   endfunction

   function automatic void predict_request(logic op, addr_t a, stamp_t t);
      int unsigned n;
      span_t       s;
      fresh_spans.delete();
      if (op == OP_SECTOR) begin
         if (t[TIME_W-1]) begin
            bad_total = bad_total + 1'b1;
            file_span(open_start, a);
            open_start = a;
         end
         return;
      end
      file_span(open_start, disk_lba_cfg);
      n = (ranks_filled > RESULT_LIMIT) ? RESULT_LIMIT : ranks_filled;
      for (int unsigned r = 0; r < n; r++) begin
         s.rank      = RANK_W'(r);
         s.from_lba  = rank_from[r];
         s.to_lba    = rank_to[r];
         s.length    = gap_len(rank_from[r], rank_to[r]);
         s.bad_count = bad_total;
         s.is_last   = (r + 1 == n);
         fresh_spans.push_back(s);
      end
      clear_scan();
   endfunction

   function automatic void check_field(string name, int r, addr_t want, addr_t got);
      if (want !== got) begin
         $display("%0t ns: rank %0d %s expected %0h, got %0h", $time, r, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : watch_rsp
      span_t want;
      if ((start && !busy) || rsp_valid || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (!reset && rsp_valid) begin
         if (span_due.size() == 0) begin
            $display("%0t ns: unexpected span, rank %0d start %0h end %0h",
                     $time, rsp_rank, rsp_span_start, rsp_span_end);
            mismatch_count++;
         end else begin
            want = span_due.pop_front();
            spans_checked++;
            check_field("rank", want.rank, addr_t'(want.rank), addr_t'(rsp_rank));
            check_field("span_start", want.rank, want.from_lba, rsp_span_start);
            check_field("span_end", want.rank, want.to_lba, rsp_span_end);
            check_field("span_length", want.rank, want.length, rsp_span_length);
            check_field("bad_count", want.rank, want.bad_count, rsp_bad_count);
            check_field("last", want.rank, addr_t'(want.is_last), addr_t'(rsp_last));
         end
      end
   end

   initial begin
      do @(posedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("%0t ns: no progress, %0d spans still expected", $time, span_due.size());
      $display("FAILED: results differ");
      $finish;
   end

   task automatic settle();
      start <= 1'b0;
      while (span_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, addr_t v);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DISK_LBA) disk_lba_cfg = v;
      else ranks_cfg = v[RANKS_W-1:0];
      csr_writes++;
   endtask

   task automatic issue(logic op, addr_t a, stamp_t t, bit typed, span_t want);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start              <= 1'b1;
      req_op             <= op;
      req_sector_address <= a;
      req_access_time    <= t;
      do @(posedge clock); while (busy);
      predict_request(op, a, t);
      if (typed) span_due.push_back(want);
      else foreach (fresh_spans[i]) span_due.push_back(fresh_spans[i]);
      if (op == OP_REPORT) reports_sent++;
      else if (t[TIME_W-1]) bad_sent++;
      else good_sent++;
   endtask

   function automatic void plan_request(logic op, addr_t a, stamp_t t, bit typed, span_t want);
      row_t r;
      r = '{ROW_REQ, op, a, t, CSR_DISK_LBA, typed, want};
      directed_plan.push_back(r);
   endfunction

   function automatic void plan_write(logic [CSR_IDX_W-1:0] idx, addr_t v);
      row_t r;
      r = '{ROW_CSR, OP_SECTOR, v, '0, idx, 1'b0, '0};
      directed_plan.push_back(r);
   endfunction

   initial begin
      int     base;
      int     records;
      int     cut;
      addr_t  cur;
      addr_t  word;
      stamp_t tm;

      disk_lba_cfg = '0;
      ranks_cfg    = RANKS_RESET;
      clear_scan();

      // report right after reset, then extremes of every field
      plan_request(OP_REPORT, LBA_MAX, 32'hFFFF_FFFF, 1'b1, '{4'd0, '0, '0, '0, '0, 1'b1});
      plan_write(CSR_DISK_LBA, LBA_MAX);
      plan_request(OP_SECTOR, 48'd100, 32'h0000_0000, 1'b0, '0);
      plan_request(OP_SECTOR, 48'd200, 32'h7FFF_FFFF, 1'b0, '0);
      plan_request(OP_REPORT, '0, '0, 1'b1, '{4'd0, '0, LBA_MAX, LBA_MAX, '0, 1'b1});
      plan_request(OP_SECTOR, LBA_MAX, 32'h8000_0000, 1'b0, '0);
      plan_request(OP_SECTOR, '0, 32'hFFFF_FFFF, 1'b0, '0);
      plan_request(OP_REPORT, LBA_MAX, 32'h8000_0000, 1'b0, '0);
      // rank limit clamped to one: backward span and short spans dropped
      plan_write(CSR_RANKS_IN_USE, '0);
      plan_request(OP_SECTOR, 48'd1000, 32'hFFFF_FFFB, 1'b0, '0);
      plan_request(OP_SECTOR, 48'd500, 32'h8000_0001, 1'b0, '0);
      plan_request(OP_SECTOR, 48'd5000, 32'hFFFF_FFFF, 1'b0, '0);
      plan_write(CSR_DISK_LBA, '0);
      plan_request(OP_REPORT, '0, '0, 1'b1,
                   '{4'd0, 48'd500, 48'd5000, 48'd4500, 48'd3, 1'b1});
      // ties, then limit lowered mid scan
      plan_write(CSR_RANKS_IN_USE, 48'd31);
      for (int i = 1; i <= 6; i++)
         plan_request(OP_SECTOR, addr_t'(i * 100), 32'hFFFF_0000 + i, 1'b0, '0);
      plan_write(CSR_RANKS_IN_USE, 48'd2);
      plan_request(OP_SECTOR, 48'd1000, 32'hC000_0000, 1'b0, '0);
      plan_request(OP_REPORT, '0, '0, 1'b0, '0);
      plan_write(CSR_RANKS_IN_USE, 48'd16);
      plan_write(CSR_DISK_LBA, 48'h8000_0000_0000);
      plan_request(OP_SECTOR, 48'h7FFF_FFFF_FFFF, 32'h8000_0000, 1'b0, '0);
      plan_request(OP_SECTOR, 48'h8000_0000_0001, 32'h1234_5678, 1'b0, '0);
      plan_request(OP_REPORT, LBA_MAX, 32'hFFFF_FFFF, 1'b0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR)
            write_csr(directed_plan[i].idx, directed_plan[i].addr);
         else
            issue(directed_plan[i].op, directed_plan[i].addr, directed_plan[i].tm,
                  directed_plan[i].typed, directed_plan[i].want);
      end

      base = good_sent + bad_sent + reports_sent;
      while (good_sent + bad_sent + reports_sent - base < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
               0: word = '0;
               1: word = LBA_MAX;
               2: word = rand48();
               default: word = addr_t'($urandom_range(0, 1 << 20));
            endcase
            write_csr(CSR_DISK_LBA, word);
         end
         if ($urandom_range(0, 1)) begin
            word = $urandom_range(0, 1) ? rand48() : '0;
            case ($urandom_range(0, 5))
               0: word[4:0] = 5'd0;
               1: word[4:0] = 5'd1;
               2: word[4:0] = 5'd16;
               3: word[4:0] = 5'd31;
               default: word[4:0] = 5'($urandom_range(2, 15));
            endcase
            write_csr(CSR_RANKS_IN_USE, word);
         end
         records = $urandom_range(0, 24);
         cut     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, records) : records + 1;
         cur     = '0;
         for (int j = 0; j < records; j++) begin
            if (j == cut)
               write_csr(CSR_RANKS_IN_USE, addr_t'($urandom_range(0, ranks_cfg)));
            case ($urandom_range(0, 9))
               0: cur = rand48();
               1: cur = cur - $urandom_range(0, 5000);
               default: cur = cur + addr_t'($urandom >> $urandom_range(0, 31)) + 1'b1;
            endcase
            case ($urandom_range(0, 7))
               0: tm = $urandom;
               1, 2: tm = {1'b0, 31'($urandom)};
               default: tm = {1'b1, 31'($urandom)};
            endcase
            issue(OP_SECTOR, cur, tm, 1'b0, '0);
         end
         issue(OP_REPORT, rand48(), $urandom, 1'b0, '0);
      end

      settle();
      $display("Run covered %0d sector records (%0d bad, %0d good) and %0d reports,",
               good_sent + bad_sent, bad_sent, good_sent, reports_sent);
      $display("with %0d ranked spans checked across %0d register writes.",
               spans_checked, csr_writes);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
